FILE: rtl/mnor_pkg.sv
package mnor_pkg;

   localparam int CHANNEL_COUNT_DEF = 16;
   localparam int NOTE_COUNT_DEF    = 128;
   localparam int PATCH_ID_BITS_DEF = 8;

   localparam logic OP_ROUTE   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_CONTROL  = 4'hB;
   localparam logic [3:0] KIND_SYSTEM   = 4'hF;

   localparam logic [6:0] SUSTAIN_CC     = 7'd64;
   localparam logic [6:0] SUSTAIN_ON_MIN = 7'd64;
   localparam logic [7:0] SUSTAIN_SLOT   = 8'd128;

   localparam logic OFF_NOTE    = 1'b0;
   localparam logic OFF_SUSTAIN = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] status_byte;
      logic [6:0] data_one;
      logic [6:0] data_two;
      logic [7:0] current_patch;
      logic [3:0] release_channel;
      logic [7:0] release_slot;
      logic [7:0] filter_patch;
      logic       match_any;
   } req_type;

   typedef struct packed {
      logic [7:0] target_patch;
      logic       from_store;
      logic       is_release;
      logic       off_kind;
      logic [3:0] off_channel;
      logic [6:0] off_note;
   } rsp_type;

   typedef enum logic [2:0] {
      ACT_PASS,
      ACT_STORE,
      ACT_TAKE,
      ACT_RELEASE,
      ACT_IGNORE
   } action_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

FILE: rtl/mnor_ram.sv
module mnor_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/midi_note_off_router_unit.sv
// Note-off / sustain-off router. Each accepted item reads the owner tables in the cycle it is taken and
// is resolved in the second stage once it can advance, when the entry is modified and written back and
// the result (if any) loads the output register; a write-back to the entry the next item reads is
// forwarded. The block takes one item per cycle while the result side keeps up, and every route item
// gives a result on rsp_valid through the output register. Both tables sit in single-port-write RAMs;
// after reset a clearing pass writes the CHANNEL_COUNT*NOTE_COUNT note entries and the sustain entries,
// one note entry a cycle, and req_stall stays high for its whole length.
module midi_note_off_router_unit #(
   parameter int CHANNEL_COUNT = mnor_pkg::CHANNEL_COUNT_DEF,
   parameter int NOTE_COUNT    = mnor_pkg::NOTE_COUNT_DEF,
   parameter int PATCH_ID_BITS = mnor_pkg::PATCH_ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mnor_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mnor_pkg::rsp_type rsp_data
);

   import mnor_pkg::*;

   localparam int NoteDepth    = CHANNEL_COUNT * NOTE_COUNT;
   localparam int NoteAddrBits = (NoteDepth > 1) ? $clog2(NoteDepth) : 1;
   localparam int SusAddrBits  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int EntryBits    = PATCH_ID_BITS + 1;

   state_type state_ff, state_in;
   logic [NoteAddrBits-1:0] clr_cnt_ff, clr_cnt_in;
   logic clearing;

   logic                     s1_valid_ff, s1_valid_in;
   action_type               s1_action_ff, s1_action_in;
   logic                     s1_use_sus_ff, s1_use_sus_in;
   logic [3:0]               s1_ch_ff, s1_ch_in;
   logic [6:0]               s1_note_ff, s1_note_in;
   logic [PATCH_ID_BITS-1:0] s1_patch_ff, s1_patch_in;
   logic                     s1_any_ff, s1_any_in;
   logic [NoteAddrBits-1:0]  s1_note_addr_ff, s1_note_addr_in;
   logic [SusAddrBits-1:0]   s1_sus_addr_ff, s1_sus_addr_in;
   logic                     s1_fwd_hit_ff, s1_fwd_hit_in;
   logic [EntryBits-1:0]     s1_fwd_data_ff, s1_fwd_data_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [3:0]               ch_sel;
   logic [6:0]               note_sel;
   logic [PATCH_ID_BITS-1:0] patch_sel;
   logic                     any_sel;
   logic                     use_sus_sel;
   action_type               action_sel;
   logic [NoteAddrBits-1:0]  note_addr_sel;
   logic [SusAddrBits-1:0]   sus_addr_sel;
   logic [3:0]               msg_kind;
   logic [3:0]               msg_ch;
   logic                     chan_ok;

   logic [EntryBits-1:0]     note_rd, sus_rd, entry;
   logic                     ent_valid;
   logic [PATCH_ID_BITS-1:0] ent_patch;
   logic                     has_res, wb_en;
   logic [EntryBits-1:0]     wb_data;
   rsp_type                  res;
   logic                     s1_adv, accept;

   logic                    note_wr_en, sus_wr_en;
   logic [NoteAddrBits-1:0] note_wr_addr;
   logic [SusAddrBits-1:0]  sus_wr_addr;
   logic [EntryBits-1:0]    note_wr_data, sus_wr_data;

   // clearing pass sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == NoteAddrBits'(NoteDepth - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // decode incoming item
   always_comb begin
      msg_kind    = req_data.status_byte[7:4];
      msg_ch      = req_data.status_byte[3:0];
      chan_ok     = req_data.status_byte[7] && (msg_kind != KIND_SYSTEM)
                    && (32'(msg_ch) < CHANNEL_COUNT);
      ch_sel      = msg_ch;
      note_sel    = req_data.data_one;
      patch_sel   = PATCH_ID_BITS'(req_data.current_patch);
      any_sel     = 1'b0;
      use_sus_sel = 1'b0;
      action_sel  = ACT_PASS;
      if (req_data.operation == OP_ROUTE) begin
         if (chan_ok) begin
            if (((msg_kind == KIND_NOTE_OFF) || (msg_kind == KIND_NOTE_ON))
                && (32'(req_data.data_one) < NOTE_COUNT)) begin
               action_sel = ((msg_kind == KIND_NOTE_ON) && (req_data.data_two != 7'd0))
                            ? ACT_STORE : ACT_TAKE;
            end else if ((msg_kind == KIND_CONTROL) && (req_data.data_one == SUSTAIN_CC)) begin
               use_sus_sel = 1'b1;
               action_sel  = (req_data.data_two >= SUSTAIN_ON_MIN) ? ACT_STORE : ACT_TAKE;
            end
         end
      end else begin
         ch_sel     = req_data.release_channel;
         note_sel   = req_data.release_slot[6:0];
         patch_sel  = PATCH_ID_BITS'(req_data.filter_patch);
         any_sel    = req_data.match_any;
         action_sel = ACT_IGNORE;
         if (32'(req_data.release_channel) < CHANNEL_COUNT) begin
            if (req_data.release_slot == SUSTAIN_SLOT) begin
               use_sus_sel = 1'b1;
               note_sel    = 7'd0;
               action_sel  = ACT_RELEASE;
            end else if (32'(req_data.release_slot) < NOTE_COUNT) begin
               action_sel  = ACT_RELEASE;
            end
         end
      end
      note_addr_sel = NoteAddrBits'(32'(ch_sel) * NOTE_COUNT + 32'(note_sel));
      sus_addr_sel  = SusAddrBits'(ch_sel);
   end

   // resolve the item held in the second stage
   always_comb begin
      entry     = s1_fwd_hit_ff ? s1_fwd_data_ff : (s1_use_sus_ff ? sus_rd : note_rd);
      ent_valid = entry[PATCH_ID_BITS];
      ent_patch = entry[PATCH_ID_BITS-1:0];
      has_res   = 1'b0;
      wb_en     = 1'b0;
      wb_data   = '0;
      res       = '0;
      res.target_patch = 8'(s1_patch_ff);
      case (s1_action_ff)
         ACT_PASS: begin
            has_res = 1'b1;
         end
         ACT_STORE: begin
            has_res = 1'b1;
            wb_en   = 1'b1;
            wb_data = {1'b1, s1_patch_ff};
         end
         ACT_TAKE: begin
            has_res = 1'b1;
            if (ent_valid) begin
               wb_en            = 1'b1;
               res.target_patch = 8'(ent_patch);
               res.from_store   = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (ent_valid && (s1_any_ff || (ent_patch == s1_patch_ff))) begin
               has_res          = 1'b1;
               wb_en            = 1'b1;
               res.target_patch = 8'(ent_patch);
               res.from_store   = 1'b1;
               res.is_release   = 1'b1;
               res.off_kind     = s1_use_sus_ff ? OFF_SUSTAIN : OFF_NOTE;
               res.off_channel  = s1_ch_ff;
               res.off_note     = s1_note_ff;
            end
         end
         ACT_IGNORE: begin
            has_res = 1'b0;
         end
         default: begin
            has_res = 1'b0;
         end
      endcase
   end

   assign s1_adv    = s1_valid_ff && (!has_res || !rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_action_in    = s1_action_ff;
      s1_use_sus_in   = s1_use_sus_ff;
      s1_ch_in        = s1_ch_ff;
      s1_note_in      = s1_note_ff;
      s1_patch_in     = s1_patch_ff;
      s1_any_in       = s1_any_ff;
      s1_note_addr_in = s1_note_addr_ff;
      s1_sus_addr_in  = s1_sus_addr_ff;
      s1_fwd_hit_in   = s1_fwd_hit_ff;
      s1_fwd_data_in  = s1_fwd_data_ff;
      s1_valid_in     = s1_valid_ff && !s1_adv;
      if (accept) begin
         s1_valid_in     = 1'b1;
         s1_action_in    = action_sel;
         s1_use_sus_in   = use_sus_sel;
         s1_ch_in        = ch_sel;
         s1_note_in      = note_sel;
         s1_patch_in     = patch_sel;
         s1_any_in       = any_sel;
         s1_note_addr_in = note_addr_sel;
         s1_sus_addr_in  = sus_addr_sel;
         // forward a write-back to the entry being read in this cycle
         s1_fwd_hit_in   = s1_adv && wb_en && (use_sus_sel == s1_use_sus_ff)
                           && (use_sus_sel ? (sus_addr_sel == s1_sus_addr_ff)
                                           : (note_addr_sel == s1_note_addr_ff));
         s1_fwd_data_in  = wb_data;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv && has_res) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_comb begin
      note_wr_en   = clearing || (s1_adv && wb_en && !s1_use_sus_ff);
      note_wr_addr = clearing ? clr_cnt_ff : s1_note_addr_ff;
      note_wr_data = clearing ? '0 : wb_data;
      sus_wr_en    = clearing ? (32'(clr_cnt_ff) < CHANNEL_COUNT)
                              : (s1_adv && wb_en && s1_use_sus_ff);
      sus_wr_addr  = clearing ? clr_cnt_ff[SusAddrBits-1:0] : s1_sus_addr_ff;
      sus_wr_data  = clearing ? '0 : wb_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_action_ff    <= s1_action_in;
      s1_use_sus_ff   <= s1_use_sus_in;
      s1_ch_ff        <= s1_ch_in;
      s1_note_ff      <= s1_note_in;
      s1_patch_ff     <= s1_patch_in;
      s1_any_ff       <= s1_any_in;
      s1_note_addr_ff <= s1_note_addr_in;
      s1_sus_addr_ff  <= s1_sus_addr_in;
      s1_fwd_hit_ff   <= s1_fwd_hit_in;
      s1_fwd_data_ff  <= s1_fwd_data_in;
      rsp_data_ff     <= rsp_data_in;
   end

   mnor_ram #(
      .WIDTH(EntryBits),
      .DEPTH(NoteDepth)
   ) u_note_ram (
      .clock  (clock),
      .wr_en  (note_wr_en),
      .wr_addr(note_wr_addr),
      .wr_data(note_wr_data),
      .rd_en  (accept),
      .rd_addr(note_addr_sel),
      .rd_data(note_rd)
   );

   mnor_ram #(
      .WIDTH(EntryBits),
      .DEPTH(CHANNEL_COUNT)
   ) u_sus_ram (
      .clock  (clock),
      .wr_en  (sus_wr_en),
      .wr_addr(sus_wr_addr),
      .wr_data(sus_wr_data),
      .rd_en  (accept),
      .rd_addr(sus_addr_sel),
      .rd_data(sus_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/mnor_checker.sv
module mnor_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mnor_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mnor_pkg::rsp_type rsp_data
);

   import mnor_pkg::*;

   // input must be held off as reset falls, when the clearing of the tables begins
   a_clear_stall: assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("input taken right after reset");

   a_route_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.operation == OP_ROUTE)) |-> ##2 rsp_valid)
      else $error("route item gave no result");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind midi_note_off_router_unit mnor_checker u_mnor_checker (.*);
